### hdl/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
// Used by the front end, back end, top level and testbench; depends on nothing.
`timescale 1ns / 1ps

package mlfq_pkg;

   localparam int KIND_W   = 3;
   localparam int TID_W    = 6;
   localparam int LVL_W    = 3;
   localparam int SLICE_W  = 23;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int UNIT_W   = 20;
   localparam int LIMIT_W  = 7;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [KIND_W-1:0] KIND_CREATE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EXPIRE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_YIELD  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EXIT   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_JOIN   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_TERM = 2'd3;

   localparam logic REG_SLICE_UNIT   = 1'b0;
   localparam logic REG_THREAD_LIMIT = 1'b1;

   localparam logic [UNIT_W-1:0]  SLICE_UNIT_RESET   = 20'd25000;
   localparam logic [LIMIT_W-1:0] THREAD_LIMIT_RESET = 7'd64;

   typedef enum logic [2:0] {
      OP_CREATE = 3'd0,
      OP_EXPIRE = 3'd1,
      OP_YIELD  = 3'd2,
      OP_EXIT   = 3'd3,
      OP_JOIN   = 3'd4
   } op_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TID_W-1:0]  target_thread;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TID_W-1:0]    thread_id;
      logic [LVL_W-1:0]    level;
      logic [SLICE_W-1:0]  slice_length;
      logic [COUNT_W-1:0]  active_count;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      logic [TID_W-1:0] target;
   } cmd_type;

endpackage

### hdl/mlfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the per-slot queue links; depends on nothing.
`timescale 1ns / 1ps

module mlfq_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/mlfq_front.sv
// Front end: takes event transfers, decodes the kind, drops unknown kinds
// and holds decoded commands in a two-entry queue. Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mlfq_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output mlfq_pkg::cmd_type cmd
);

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   mlfq_pkg::cmd_type entry_ff [DEPTH];
   mlfq_pkg::cmd_type entry_in [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              known;
   mlfq_pkg::op_type  op;
   logic              push, pop;

   always_comb begin
      known = 1'b1;
      op    = mlfq_pkg::OP_CREATE;
      unique case (req_data.kind)
         mlfq_pkg::KIND_CREATE: op = mlfq_pkg::OP_CREATE;
         mlfq_pkg::KIND_EXPIRE: op = mlfq_pkg::OP_EXPIRE;
         mlfq_pkg::KIND_YIELD:  op = mlfq_pkg::OP_YIELD;
         mlfq_pkg::KIND_EXIT:   op = mlfq_pkg::OP_EXIT;
         mlfq_pkg::KIND_JOIN:   op = mlfq_pkg::OP_JOIN;
         default:               known = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != CW'(DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready && known;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff].op     = op;
         entry_in[wr_ptr_ff].target = req_data.target_thread;
         wr_ptr_in                  = wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/mlfq_back.sv
// Back end: sequencer that carries out one scheduling command at a time on the
// level queues, slot flags and link RAM, and drives the result register.
// Depends on mlfq_pkg and mlfq_ram.
`timescale 1ns / 1ps

module mlfq_back #(
   parameter int LEVELS = 5,
   parameter int SLOTS  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  mlfq_pkg::cmd_type             cmd,
   input  logic [mlfq_pkg::UNIT_W-1:0]   slice_unit,
   input  logic [mlfq_pkg::LIMIT_W-1:0]  thread_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mlfq_pkg::rsp_type             rsp_data
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LW     = $clog2(LEVELS);
   localparam int GROUP  = 8;
   localparam int POS_W  = $clog2(GROUP);
   localparam int GROUPS = (SLOTS + GROUP - 1) / GROUP;
   localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int TW     = ((SLOT_W > mlfq_pkg::TID_W) ? SLOT_W : mlfq_pkg::TID_W) + 1;
   localparam int PROD_W = LW + 1 + mlfq_pkg::UNIT_W;
   localparam logic [LW-1:0] LAST_LEVEL = LW'(LEVELS - 1);
   localparam logic [GW-1:0] LAST_GROUP = GW'(GROUPS - 1);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SEARCH   = 9'b000000010,
      ST_CREATE   = 9'b000000100,
      ST_REFUSE   = 9'b000001000,
      ST_LINK_RD  = 9'b000010000,
      ST_POP      = 9'b000100000,
      ST_PUSH     = 9'b001000000,
      ST_DISPATCH = 9'b010000000,
      ST_JOIN     = 9'b100000000
   } state_type;

   state_type                      state_ff, state_in;
   mlfq_pkg::op_type               op_ff, op_in;
   logic [mlfq_pkg::TID_W-1:0]     target_ff, target_in;
   logic [SLOT_W-1:0]              head_ff [LEVELS];
   logic [SLOT_W-1:0]              head_in [LEVELS];
   logic [SLOT_W-1:0]              tail_ff [LEVELS];
   logic [SLOT_W-1:0]              tail_in [LEVELS];
   logic [LEVELS-1:0]              occ_ff, occ_in;
   logic [SLOTS-1:0]               free_ff, free_in;
   logic [SLOTS-1:0]               term_ff, term_in;
   logic [SLOT_W-1:0]              cur_ff, cur_in;
   logic [LW-1:0]                  cur_level_ff, cur_level_in;
   logic                           running_ff, running_in;
   logic [mlfq_pkg::COUNT_W-1:0]   created_ff, created_in;
   logic [GW-1:0]                  group_ff, group_in;
   logic [SLOT_W-1:0]              slot_ff, slot_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   mlfq_pkg::rsp_type              rsp_ff, rsp_in;

   logic                           out_free;
   logic [LW-1:0]                  head_idx, tail_idx;
   logic [SLOT_W-1:0]              head_rd, tail_rd;
   logic                           disp_found;
   logic [LW-1:0]                  disp_lv;
   logic [LW:0]                    lv_step;
   logic [PROD_W-1:0]              slice_prod;
   logic [GROUPS*GROUP-1:0]        free_pad;
   logic [GROUP-1:0]               chunk;
   logic                           chunk_any;
   logic [POS_W-1:0]               chunk_pos;
   logic [GW+POS_W-1:0]            found_wide;
   logic [TW-1:0]                  tgt_ext;
   logic [SLOT_W-1:0]              tgt_idx;
   logic                           join_ok;
   logic                           link_we;
   logic [SLOT_W-1:0]              link_wdata;
   logic [SLOT_W-1:0]              link_rdata;

   function automatic mlfq_pkg::rsp_type pack_rsp(
      input logic [mlfq_pkg::STATUS_W-1:0] status,
      input logic [mlfq_pkg::TID_W-1:0]    thread_id,
      input logic [mlfq_pkg::LVL_W-1:0]    level,
      input logic [mlfq_pkg::SLICE_W-1:0]  slice_length,
      input logic [mlfq_pkg::COUNT_W-1:0]  active_count
   );
      mlfq_pkg::rsp_type r;
      r.status       = status;
      r.thread_id    = thread_id;
      r.level        = level;
      r.slice_length = slice_length;
      r.active_count = active_count;
      return r;
   endfunction

   assign cmd_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign head_idx   = (state_ff == ST_DISPATCH) ? disp_lv : cur_level_ff;
   assign tail_idx   = (state_ff == ST_CREATE) ? '0 : cur_level_ff;
   assign head_rd    = head_ff[head_idx];
   assign tail_rd    = tail_ff[tail_idx];
   assign link_wdata = (state_ff == ST_CREATE) ? slot_ff : cur_ff;

   always_comb begin
      disp_found = 1'b0;
      disp_lv    = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (occ_ff[i]) begin
            disp_found = 1'b1;
            disp_lv    = LW'(i);
         end
      end
   end

   assign lv_step    = (LW + 1)'(disp_lv) + (LW + 1)'(1);
   assign slice_prod = PROD_W'(lv_step) * PROD_W'(slice_unit);

   assign free_pad  = (GROUPS * GROUP)'(free_ff);
   assign chunk     = free_pad[group_ff * GROUP +: GROUP];
   assign chunk_any = |chunk;

   always_comb begin
      chunk_pos = '0;
      for (int i = GROUP - 1; i >= 0; i--) begin
         if (chunk[i]) begin
            chunk_pos = POS_W'(i);
         end
      end
   end

   assign found_wide = {group_ff, chunk_pos};
   assign tgt_ext    = TW'(target_ff);
   assign tgt_idx    = tgt_ext[SLOT_W-1:0];
   assign join_ok    = (tgt_ext < TW'(SLOTS)) && term_ff[tgt_idx];

   mlfq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (tail_rd),
      .wr_data (link_wdata),
      .rd_addr (cur_ff),
      .rd_data (link_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      target_in    = target_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      free_in      = free_ff;
      term_in      = term_ff;
      cur_in       = cur_ff;
      cur_level_in = cur_level_ff;
      running_in   = running_ff;
      created_in   = created_ff;
      group_in     = group_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      link_we      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               op_in     = cmd.op;
               target_in = cmd.target;
               group_in  = '0;
               unique case (cmd.op) inside
                  mlfq_pkg::OP_CREATE: begin
                     state_in = (created_ff < thread_limit) ? ST_SEARCH : ST_REFUSE;
                  end
                  mlfq_pkg::OP_EXPIRE, mlfq_pkg::OP_YIELD, mlfq_pkg::OP_EXIT: begin
                     state_in = running_ff ? ST_LINK_RD : ST_DISPATCH;
                  end
                  mlfq_pkg::OP_JOIN: state_in = ST_JOIN;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (chunk_any) begin
               slot_in  = found_wide[SLOT_W-1:0];
               state_in = ST_CREATE;
            end else if (group_ff == LAST_GROUP) begin
               state_in = ST_REFUSE;
            end else begin
               group_in = group_ff + GW'(1);
            end
         end
         ST_CREATE: begin
            if (out_free) begin
               free_in[slot_ff] = 1'b0;
               if (occ_ff[0]) begin
                  link_we    = 1'b1;
                  tail_in[0] = slot_ff;
               end else begin
                  head_in[0] = slot_ff;
                  tail_in[0] = slot_ff;
                  occ_in[0]  = 1'b1;
               end
               created_in   = created_ff + mlfq_pkg::COUNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = pack_rsp(mlfq_pkg::STATUS_OK, mlfq_pkg::TID_W'(slot_ff),
                                       '0, '0, created_ff + mlfq_pkg::COUNT_W'(1));
               state_in     = ST_IDLE;
            end
         end
         ST_REFUSE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pack_rsp(mlfq_pkg::STATUS_FULL, '0, '0, '0, created_ff);
               state_in     = ST_IDLE;
            end
         end
         ST_LINK_RD: begin
            state_in = ST_POP;
         end
         ST_POP: begin
            if (head_rd == tail_rd) begin
               occ_in[cur_level_ff] = 1'b0;
            end else begin
               head_in[cur_level_ff] = link_rdata;
            end
            running_in = 1'b0;
            if (op_ff == mlfq_pkg::OP_EXIT) begin
               term_in[cur_ff] = 1'b1;
               state_in        = ST_DISPATCH;
            end else begin
               if (op_ff == mlfq_pkg::OP_YIELD || cur_level_ff == LAST_LEVEL) begin
                  cur_level_in = LAST_LEVEL;
               end else begin
                  cur_level_in = cur_level_ff + LW'(1);
               end
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (occ_ff[cur_level_ff]) begin
               link_we               = 1'b1;
               tail_in[cur_level_ff] = cur_ff;
            end else begin
               head_in[cur_level_ff] = cur_ff;
               tail_in[cur_level_ff] = cur_ff;
               occ_in[cur_level_ff]  = 1'b1;
            end
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (disp_found) begin
                  cur_in       = head_rd;
                  cur_level_in = disp_lv;
                  running_in   = 1'b1;
                  rsp_in       = pack_rsp(mlfq_pkg::STATUS_OK, mlfq_pkg::TID_W'(head_rd),
                                          mlfq_pkg::LVL_W'(disp_lv),
                                          mlfq_pkg::SLICE_W'(slice_prod), created_ff);
               end else begin
                  rsp_in = pack_rsp(mlfq_pkg::STATUS_NONE, '0, '0, '0, created_ff);
               end
               state_in = ST_IDLE;
            end
         end
         ST_JOIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (join_ok) begin
                  term_in[tgt_idx] = 1'b0;
                  free_in[tgt_idx] = 1'b1;
                  created_in       = (created_ff != '0) ?
                                     created_ff - mlfq_pkg::COUNT_W'(1) : '0;
                  rsp_in           = pack_rsp(mlfq_pkg::STATUS_OK, target_ff, '0, '0,
                                              (created_ff != '0) ?
                                              created_ff - mlfq_pkg::COUNT_W'(1) : '0);
               end else begin
                  rsp_in = pack_rsp(mlfq_pkg::STATUS_NOT_TERM, target_ff, '0, '0,
                                    created_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      target_ff <= target_in;
      group_ff  <= group_in;
      slot_ff   <= slot_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '{default: '0};
         tail_ff      <= '{default: '0};
         occ_ff       <= LEVELS'(1);
         free_ff      <= {{(SLOTS - 1){1'b1}}, 1'b0};
         term_ff      <= '0;
         cur_ff       <= '0;
         cur_level_ff <= '0;
         running_ff   <= 1'b1;
         created_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         free_ff      <= free_in;
         term_ff      <= term_in;
         cur_ff       <= cur_in;
         cur_level_ff <= cur_level_in;
         running_ff   <= running_in;
         created_ff   <= created_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/mlfq_thread_scheduler.sv
// Top level of the multilevel feedback queue thread scheduler: APB register
// file, front end, back end and checks. Depends on mlfq_pkg, mlfq_front, mlfq_back.
`timescale 1ns / 1ps

// Usage
//  req channel: one scheduling event per transfer (kind, target_thread).
//    Kinds 5 to 7 are taken and dropped without a result.
//  rsp channel: one result per known event, in event order.
//  APB port: slice_unit at 0x0, thread_limit at 0x4; write only while idle.
//  A two-entry command queue sits between the event decoder and the
//  sequencer, so events are taken while a result waits to be transferred.
//  Sequencer states per event: join JOIN; create at the thread limit
//  REFUSE; dispatch with no running thread DISPATCH; exit LINK_RD, POP,
//  DISPATCH; slice expiry and yield LINK_RD (registered read of the link
//  RAM before the requeue), POP, PUSH, DISPATCH; create SEARCH, one group
//  of eight slots per step for the lowest free slot, then CREATE or REFUSE.
//  Reset: slot 0 runs at level 0, all other slots free, no thread counted,
//  registers at their reset values. No clearing pass.
//  A stalled rsp receiver holds the result register; the sequencer waits on
//  it and the queue fills, after which req_ready drops.
module mlfq_thread_scheduler #(
   parameter int LEVELS = 5,
   parameter int SLOTS  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mlfq_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mlfq_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mlfq_pkg::ADDR_W-1:0]   paddr,
   input  logic [mlfq_pkg::DATA_W-1:0]   pwdata,
   output logic [mlfq_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   logic [mlfq_pkg::UNIT_W-1:0]  slice_unit_ff, slice_unit_in;
   logic [mlfq_pkg::LIMIT_W-1:0] thread_limit_ff, thread_limit_in;
   logic                         reg_index;
   logic                         cfg_write;
   logic                         cmd_valid;
   logic                         cmd_ready;
   mlfq_pkg::cmd_type            cmd;

   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      slice_unit_in   = slice_unit_ff;
      thread_limit_in = thread_limit_ff;
      prdata          = '0;
      unique case (reg_index)
         mlfq_pkg::REG_SLICE_UNIT: begin
            prdata = mlfq_pkg::DATA_W'(slice_unit_ff);
            if (cfg_write) begin
               slice_unit_in = pwdata[mlfq_pkg::UNIT_W-1:0];
            end
         end
         mlfq_pkg::REG_THREAD_LIMIT: begin
            prdata = mlfq_pkg::DATA_W'(thread_limit_ff);
            if (cfg_write) begin
               thread_limit_in = pwdata[mlfq_pkg::LIMIT_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_unit_ff   <= mlfq_pkg::SLICE_UNIT_RESET;
         thread_limit_ff <= mlfq_pkg::THREAD_LIMIT_RESET;
      end else begin
         slice_unit_ff   <= slice_unit_in;
         thread_limit_ff <= thread_limit_in;
      end
   end

   mlfq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   mlfq_back #(
      .LEVELS (LEVELS),
      .SLOTS  (SLOTS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .slice_unit   (slice_unit_ff),
      .thread_limit (thread_limit_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   a_full_queue_offers: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> cmd_valid)
      else $error("event queue full but no command offered to sequencer");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_ready |=> !cmd_ready)
      else $error("sequencer took a command and stayed idle");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(cmd_ready))
      else $error("result raised while sequencer was idle");

endmodule

### dv/tb_mlfq_thread_scheduler.sv
// Self-checking testbench for the multilevel feedback queue thread scheduler.
// Depends on mlfq_pkg and mlfq_thread_scheduler; predicts every result from its own
// copy of the level queues, slot table and registers.
`timescale 1ns / 1ps

module tb_mlfq_thread_scheduler;

   localparam int LEVELS         = 5;
   localparam int SLOTS          = 64;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_EVENTS   = 190;

   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_READY   = 2'd1,
      SLOT_RUNNING = 2'd2,
      SLOT_DONE    = 2'd3
   } slot_state_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   mlfq_pkg::req_type           req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   mlfq_pkg::rsp_type           rsp_data;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [mlfq_pkg::ADDR_W-1:0] paddr = '0;
   logic [mlfq_pkg::DATA_W-1:0] pwdata = '0;
   logic [mlfq_pkg::DATA_W-1:0] prdata;
   logic                        pready;

   // scheduler image
   logic [mlfq_pkg::UNIT_W-1:0]  unit_reg;
   logic [mlfq_pkg::LIMIT_W-1:0] limit_reg;
   logic [mlfq_pkg::TID_W-1:0]   lvl_head [LEVELS];
   logic [mlfq_pkg::TID_W-1:0]   lvl_tail [LEVELS];
   bit                           lvl_busy [LEVELS];
   logic [mlfq_pkg::TID_W-1:0]   next_slot [SLOTS];
   logic [mlfq_pkg::LVL_W-1:0]   slot_lvl [SLOTS];
   slot_state_type               slot_state [SLOTS];
   logic [mlfq_pkg::TID_W-1:0]   running_slot;
   logic [mlfq_pkg::COUNT_W-1:0] live_count;

   mlfq_pkg::rsp_type pending_results[$];

   int unsigned tx_idle_pct = 0;
   int unsigned rx_stall_pct = 0;
   int unsigned holdoff_asked = 0;
   int unsigned holdoff_taken = 0;
   int unsigned holdoff_left = 0;
   int unsigned quiet_cycles = 0;

   int unsigned fail_count = 0;
   int unsigned events_sent = 0;
   int unsigned ignored_sent = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used = 0;
   int unsigned status_seen [4] = '{0, 0, 0, 0};

   mlfq_thread_scheduler #(
      .LEVELS(LEVELS),
      .SLOTS (SLOTS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("MISMATCH %0t: %s", $time, msg);
      end
   endfunction

   function automatic void scheduler_reset();
      unit_reg     = mlfq_pkg::SLICE_UNIT_RESET;
      limit_reg    = mlfq_pkg::THREAD_LIMIT_RESET;
      running_slot = '0;
      live_count   = '0;
      for (int l = 0; l < LEVELS; l++) begin
         lvl_head[l] = '0;
         lvl_tail[l] = '0;
         lvl_busy[l] = (l == 0);
      end
      for (int s = 0; s < SLOTS; s++) begin
         next_slot[s]  = '0;
         slot_lvl[s]   = '0;
         slot_state[s] = (s == 0) ? SLOT_RUNNING : SLOT_FREE;
      end
   endfunction

   function automatic void level_push(input int lv, input logic [mlfq_pkg::TID_W-1:0] s);
      if (!lvl_busy[lv]) begin
         lvl_head[lv] = s;
         lvl_tail[lv] = s;
         lvl_busy[lv] = 1'b1;
      end else begin
         next_slot[lvl_tail[lv]] = s;
         lvl_tail[lv] = s;
      end
   endfunction

   function automatic void level_pop(input int lv);
      if (lvl_busy[lv]) begin
         if (lvl_head[lv] == lvl_tail[lv]) begin
            lvl_busy[lv] = 1'b0;
         end else begin
            lvl_head[lv] = next_slot[lvl_head[lv]];
         end
      end
   endfunction

   function automatic mlfq_pkg::rsp_type dispatch_next();
      mlfq_pkg::rsp_type r;
      bit                taken;
      r = '0;
      taken = 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
         if (!taken && lvl_busy[l]) begin
            taken = 1'b1;
            slot_state[lvl_head[l]] = SLOT_RUNNING;
            running_slot   = lvl_head[l];
            r.thread_id    = lvl_head[l];
            r.level        = mlfq_pkg::LVL_W'(l);
            r.slice_length = mlfq_pkg::SLICE_W'(32'(l + 1) * 32'(unit_reg));
         end
      end
      if (!taken) begin
         r.status = mlfq_pkg::STATUS_NONE;
      end
      return r;
   endfunction

   // returns 0 for events the block drops without a result
   function automatic bit predict_event(input mlfq_pkg::req_type ev,
                                        output mlfq_pkg::rsp_type res);
      mlfq_pkg::rsp_type          r;
      logic [mlfq_pkg::TID_W-1:0] cur;
      int                         lv;
      bit                         found;
      int                         pick;
      r     = '0;
      cur   = running_slot;
      found = 1'b0;
      pick  = 0;
      case (ev.kind)
         mlfq_pkg::KIND_CREATE: begin
            if (live_count < limit_reg) begin
               for (int s = 0; s < SLOTS; s++) begin
                  if (!found && slot_state[s] == SLOT_FREE) begin
                     found = 1'b1;
                     pick  = s;
                  end
               end
            end
            if (!found) begin
               r.status = mlfq_pkg::STATUS_FULL;
            end else begin
               slot_state[pick] = SLOT_READY;
               slot_lvl[pick]   = '0;
               level_push(0, mlfq_pkg::TID_W'(pick));
               live_count++;
               r.thread_id = mlfq_pkg::TID_W'(pick);
            end
         end
         mlfq_pkg::KIND_EXPIRE, mlfq_pkg::KIND_YIELD, mlfq_pkg::KIND_EXIT: begin
            if (slot_state[cur] == SLOT_RUNNING) begin
               lv = int'(slot_lvl[cur]) % LEVELS;
               level_pop(lv);
               if (ev.kind == mlfq_pkg::KIND_EXIT) begin
                  slot_state[cur] = SLOT_DONE;
               end else begin
                  if (ev.kind == mlfq_pkg::KIND_YIELD) begin
                     lv = LEVELS - 1;
                  end else if (lv < LEVELS - 1) begin
                     lv++;
                  end
                  slot_lvl[cur]   = mlfq_pkg::LVL_W'(lv);
                  slot_state[cur] = SLOT_READY;
                  level_push(lv, cur);
               end
            end
            r = dispatch_next();
         end
         mlfq_pkg::KIND_JOIN: begin
            r.thread_id = ev.target_thread;
            if (slot_state[ev.target_thread] != SLOT_DONE) begin
               r.status = mlfq_pkg::STATUS_NOT_TERM;
            end else begin
               slot_state[ev.target_thread] = SLOT_FREE;
               slot_lvl[ev.target_thread]   = '0;
               if (live_count > 0) begin
                  live_count--;
               end
            end
         end
         default: begin
            res = '0;
            return 1'b0;
         end
      endcase
      r.active_count = live_count;
      res = r;
      return 1'b1;
   endfunction

   function automatic logic [mlfq_pkg::TID_W-1:0] join_target();
      logic [mlfq_pkg::TID_W-1:0] done_slots[$];
      for (int s = 0; s < SLOTS; s++) begin
         if (slot_state[s] == SLOT_DONE) begin
            done_slots.push_back(mlfq_pkg::TID_W'(s));
         end
      end
      if (done_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
         return done_slots[$urandom_range(0, done_slots.size() - 1)];
      end
      return mlfq_pkg::TID_W'($urandom());
   endfunction

   function automatic mlfq_pkg::req_type random_event(input int unsigned create_pct);
      mlfq_pkg::req_type ev;
      int unsigned       roll;
      int unsigned       pick;
      ev.target_thread = mlfq_pkg::TID_W'($urandom());
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (roll < 3) begin
         ev.kind = mlfq_pkg::KIND_W'($urandom_range(int'(mlfq_pkg::KIND_JOIN) + 1,
                                                    (1 << mlfq_pkg::KIND_W) - 1));
      end else if (roll < 3 + create_pct) begin
         ev.kind = mlfq_pkg::KIND_CREATE;
      end else if (pick < 30) begin
         ev.kind = mlfq_pkg::KIND_EXPIRE;
      end else if (pick < 45) begin
         ev.kind = mlfq_pkg::KIND_YIELD;
      end else if (pick < 70) begin
         ev.kind = mlfq_pkg::KIND_EXIT;
      end else begin
         ev.kind = mlfq_pkg::KIND_JOIN;
         ev.target_thread = join_target();
      end
      return ev;
   endfunction

   // called and returns at a falling edge; valid stays high for a following transfer
   task automatic send_event(input mlfq_pkg::req_type ev);
      mlfq_pkg::rsp_type r;
      while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = ev;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      if (predict_event(ev, r)) begin
         pending_results.push_back(r);
         events_sent++;
      end else begin
         ignored_sent++;
      end
      @(negedge clock);
   endtask

   task automatic send_kind(input logic [mlfq_pkg::KIND_W-1:0] kind,
                            input logic [mlfq_pkg::TID_W-1:0] target);
      mlfq_pkg::req_type ev;
      ev.kind          = kind;
      ev.target_thread = target;
      send_event(ev);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [mlfq_pkg::ADDR_W-1:0] addr,
                             input logic [mlfq_pkg::DATA_W-1:0] wdata,
                             output logic [mlfq_pkg::DATA_W-1:0] rdata);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = write;
      paddr   = addr;
      pwdata  = wdata;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      rdata = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_registers(input logic [mlfq_pkg::UNIT_W-1:0] unit,
                                input logic [mlfq_pkg::LIMIT_W-1:0] limit);
      logic [mlfq_pkg::ADDR_W-1:0] unit_addr;
      logic [mlfq_pkg::ADDR_W-1:0] limit_addr;
      logic [mlfq_pkg::DATA_W-1:0] rd;
      unit_addr  = mlfq_pkg::ADDR_W'({mlfq_pkg::REG_SLICE_UNIT, 2'b00});
      limit_addr = mlfq_pkg::ADDR_W'({mlfq_pkg::REG_THREAD_LIMIT, 2'b00});
      drain_results();
      csr_access(1'b1, unit_addr, mlfq_pkg::DATA_W'(unit), rd);
      unit_reg = unit;
      csr_access(1'b1, limit_addr, mlfq_pkg::DATA_W'(limit), rd);
      limit_reg = limit;
      csr_access(1'b0, unit_addr, '0, rd);
      if (rd !== mlfq_pkg::DATA_W'(unit_reg)) begin
         note_failure($sformatf("slice_unit read back %0d, expected %0d", rd, unit_reg));
      end
      csr_access(1'b0, limit_addr, '0, rd);
      if (rd !== mlfq_pkg::DATA_W'(limit_reg)) begin
         note_failure($sformatf("thread_limit read back %0d, expected %0d", rd, limit_reg));
      end
      settings_used++;
   endtask

   always @(negedge clock) begin
      if (holdoff_asked != holdoff_taken) begin
         holdoff_taken <= holdoff_asked;
         holdoff_left  <= HOLDOFF_CYCLES;
         rsp_ready     <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      mlfq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result st=%0d id=%0d lv=%0d sl=%0d n=%0d",
                         rsp_data.status, rsp_data.thread_id, rsp_data.level,
                         rsp_data.slice_length, rsp_data.active_count));
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            status_seen[want.status]++;
            if (rsp_data.status !== want.status || rsp_data.thread_id !== want.thread_id ||
                rsp_data.level !== want.level || rsp_data.slice_length !== want.slice_length ||
                rsp_data.active_count !== want.active_count) begin
               note_failure($sformatf({"result %0d: expected st=%0d id=%0d lv=%0d sl=%0d n=%0d,",
                                       " got st=%0d id=%0d lv=%0d sl=%0d n=%0d"},
                  results_checked, want.status, want.thread_id, want.level,
                  want.slice_length, want.active_count, rsp_data.status, rsp_data.thread_id,
                  rsp_data.level, rsp_data.slice_length, rsp_data.active_count));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_mlfq_thread_scheduler NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_directed_events();
      tx_idle_pct  = 28;
      rx_stall_pct = 28;
      send_kind(mlfq_pkg::KIND_JOIN, 6'd0);
      send_kind(mlfq_pkg::KIND_JOIN, 6'h3F);
      send_kind(mlfq_pkg::KIND_EXPIRE, 6'h2A);
      send_kind(mlfq_pkg::KIND_CREATE, 6'h15);
      send_kind(mlfq_pkg::KIND_CREATE, 6'h00);
      send_kind(mlfq_pkg::KIND_YIELD, 6'h3F);
      send_kind(mlfq_pkg::KIND_EXPIRE, 6'h00);
      send_kind(mlfq_pkg::KIND_EXIT, 6'h00);
      send_kind(mlfq_pkg::KIND_JOIN, 6'd2);
      repeat (4) send_kind(mlfq_pkg::KIND_EXPIRE, 6'h00);
      repeat (3) send_kind(mlfq_pkg::KIND_EXIT, 6'h00);
      send_kind(mlfq_pkg::KIND_EXPIRE, 6'h00);
      send_kind(mlfq_pkg::KIND_YIELD, 6'h00);
      send_kind(mlfq_pkg::KIND_EXIT, 6'h00);
      send_kind(mlfq_pkg::KIND_JOIN, 6'd0);
      send_kind(mlfq_pkg::KIND_JOIN, 6'd1);
      send_kind(mlfq_pkg::KIND_JOIN, 6'd2);
      send_kind(mlfq_pkg::KIND_W'(int'(mlfq_pkg::KIND_JOIN) + 1), 6'h2A);
      send_kind(mlfq_pkg::KIND_W'((1 << mlfq_pkg::KIND_W) - 1), 6'h15);
      send_kind(mlfq_pkg::KIND_CREATE, 6'h00);
      drain_results();
   endtask

   task automatic test_register_extremes();
      set_registers('0, '0);
      send_kind(mlfq_pkg::KIND_CREATE, 6'h00);
      send_kind(mlfq_pkg::KIND_EXPIRE, 6'h00);
      set_registers(mlfq_pkg::UNIT_W'(1), mlfq_pkg::LIMIT_W'(1));
      send_kind(mlfq_pkg::KIND_CREATE, 6'h00);
      send_kind(mlfq_pkg::KIND_CREATE, 6'h00);
      send_kind(mlfq_pkg::KIND_YIELD, 6'h00);
      send_kind(mlfq_pkg::KIND_EXPIRE, 6'h00);
      set_registers(mlfq_pkg::UNIT_W'(1000000), mlfq_pkg::LIMIT_W'(SLOTS));
      send_kind(mlfq_pkg::KIND_YIELD, 6'h00);
      send_kind(mlfq_pkg::KIND_EXPIRE, 6'h00);
      drain_results();
   endtask

   task automatic test_backpressure();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      holdoff_asked++;
      repeat (30) send_event(random_event(30));
      drain_results();
      tx_idle_pct  = 28;
      rx_stall_pct = 28;
   endtask

   task automatic test_random_traffic();
      mlfq_pkg::req_type ev;
      int unsigned       count;
      int unsigned       create_pct;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_registers(mlfq_pkg::SLICE_UNIT_RESET, mlfq_pkg::THREAD_LIMIT_RESET);
            1: set_registers(mlfq_pkg::UNIT_W'(1), mlfq_pkg::LIMIT_W'(1));
            2: set_registers(mlfq_pkg::UNIT_W'(1000000), mlfq_pkg::LIMIT_W'(SLOTS));
            3: set_registers(mlfq_pkg::UNIT_W'($urandom_range(1, 1000000)),
                             mlfq_pkg::LIMIT_W'(SLOTS));
            4: set_registers(mlfq_pkg::UNIT_W'($urandom_range(1, 1000)),
                             mlfq_pkg::LIMIT_W'(8));
            5: set_registers(mlfq_pkg::UNIT_W'($urandom_range(1, 1000000)),
                             mlfq_pkg::LIMIT_W'($urandom_range(1, SLOTS)));
            default: set_registers(mlfq_pkg::UNIT_W'($urandom()),
                                   mlfq_pkg::LIMIT_W'($urandom_range(1, SLOTS)));
         endcase
         create_pct   = (phase == 2 || phase == 3) ? 60 : 28;
         tx_idle_pct  = (phase == 3) ? 0 : 28;
         rx_stall_pct = (phase == 3) ? 0 : 28;
         count = 0;
         while (count < PHASE_EVENTS) begin
            ev = random_event(create_pct);
            send_event(ev);
            if (ev.kind <= mlfq_pkg::KIND_JOIN) begin
               count++;
            end
         end
      end
      drain_results();
   endtask

   initial begin
      scheduler_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_events();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      $display("covered %0d events (%0d dropped kinds) over %0d register settings",
               events_sent, ignored_sent, settings_used);
      $display("results: %0d ok, %0d refused creates, %0d empty dispatches, %0d refused joins",
               status_seen[mlfq_pkg::STATUS_OK], status_seen[mlfq_pkg::STATUS_FULL],
               status_seen[mlfq_pkg::STATUS_NONE], status_seen[mlfq_pkg::STATUS_NOT_TERM]);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("tb_mlfq_thread_scheduler OK");
      end else begin
         $display("tb_mlfq_thread_scheduler NOT OK");
      end
      $finish;
   end

endmodule
